// ===== rtl/abm_pkg.sv =====
// Shared definitions for the adjacency bit matrix engine.
// Holds sizes, operation codes and the controller/datapath interface structs.
package abm_pkg;

    localparam int MAX_NODES = 64;
    localparam int ROW_BITS  = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;

    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_ERASE = 2'd1;
    localparam logic [1:0] FUNC_TEST  = 2'd2;
    localparam logic [1:0] FUNC_LIST  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic write_row;
        logic load_scan;
        logic scan_step;
        logic emit_test;
        logic emit_empty;
        logic emit_neighbor;
    } abm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       row_empty;
        logic       rem_bit0;
        logic       rem_last;
        logic       out_free;
    } abm_sts_t;

endpackage

// ===== rtl/adjacency_bit_matrix_engine.sv =====
// Adjacency bit matrix engine: 64 nodes, one 64-bit edge row per node. Every
// transaction first reads its row from the row memory into a register, then
// acts on the registered row; a test or an empty listing waits there while the
// output register is occupied. A neighbor listing walks the row one bit a
// cycle, pausing on a neighbor while the output register is occupied, up to the
// highest set bit below the node count, and emits each neighbor as it passes. An
// empty row gives a single result with neighbor_valid low. Results wait in an
// output register, and the scan pauses while that register is occupied. No
// clearing pass is needed after reset: per-row valid bits make unwritten rows read as empty.
// Depends on abm_pkg, abm_ctrl and abm_datapath.
module adjacency_bit_matrix_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration: node_count.
    input  logic                      cfg_wr_en,
    input  logic [abm_pkg::CNT_W-1:0] cfg_wr_data,
    // Input channel.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,  // node_a[5:0], node_b[11:6], zero[15:12]
    input  logic [1:0]                s_tuser,  // func[1:0]
    // Result channel.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,  // connected[0], neighbor[6:1], neighbor_valid[7]
    output logic                      m_tlast
);
    import abm_pkg::*;

    abm_cmd_t          cmd;
    abm_sts_t          sts;
    logic              out_connected;
    logic [NODE_W-1:0] out_neighbor;
    logic              out_neighbor_valid;

    abm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    abm_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_func            (s_tuser),
        .in_node_a          (s_tdata[NODE_W-1:0]),
        .in_node_b          (s_tdata[2*NODE_W-1:NODE_W]),
        .cmd                (cmd),
        .sts                (sts),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_connected      (out_connected),
        .out_neighbor       (out_neighbor),
        .out_neighbor_valid (out_neighbor_valid),
        .out_last           (m_tlast)
    );

    assign m_tdata = {out_neighbor_valid, out_neighbor, out_connected};

endmodule

// ===== rtl/abm_ctrl.sv =====
// Controller state machine for the adjacency bit matrix engine.
// Depends on abm_pkg for operation codes and the command/status structs.
module abm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  abm_pkg::abm_sts_t sts,
    output abm_pkg::abm_cmd_t cmd
);
    import abm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The row read issued at accept is now registered.
                case (sts.func)
                    FUNC_SET, FUNC_ERASE: begin
                        cmd.write_row = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    FUNC_TEST: begin
                        if (sts.out_free) begin
                            cmd.emit_test = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    default: begin
                        if (sts.row_empty) begin
                            if (sts.out_free) begin
                                cmd.emit_empty = 1'b1;
                                state_next     = ST_IDLE;
                            end
                        end else begin
                            cmd.load_scan = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                if (sts.rem_bit0) begin
                    if (sts.out_free) begin
                        cmd.emit_neighbor = 1'b1;
                        cmd.scan_step     = 1'b1;
                        if (sts.rem_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not move to execute");

    a_emit_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_test, cmd.emit_empty, cmd.emit_neighbor}))
        else $error("more than one result loaded in a cycle");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_test || cmd.emit_empty || cmd.emit_neighbor) |-> sts.out_free)
        else $error("result loaded into an occupied output register");

    a_scan_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_neighbor && sts.rem_last) |=> (state_reg == ST_IDLE))
        else $error("scan continued after the last neighbor");

endmodule

// ===== rtl/abm_datapath.sv =====
// Datapath of the adjacency bit matrix engine: row memory, row valid bits,
// neighbor scan shifter and the output register. Depends on abm_pkg.
module abm_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [abm_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic [1:0]                 in_func,
    input  logic [abm_pkg::NODE_W-1:0] in_node_a,
    input  logic [abm_pkg::NODE_W-1:0] in_node_b,
    input  abm_pkg::abm_cmd_t          cmd,
    output abm_pkg::abm_sts_t          sts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_connected,
    output logic [abm_pkg::NODE_W-1:0] out_neighbor,
    output logic                       out_neighbor_valid,
    output logic                       out_last
);
    import abm_pkg::*;

    logic [ROW_BITS-1:0]  mem_reg [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [ROW_BITS-1:0]  rd_row_reg;
    logic [1:0]           func_reg;
    logic [NODE_W-1:0]    a_reg;
    logic [NODE_W-1:0]    b_reg;
    logic [CNT_W-1:0]     node_count_reg;
    logic [ROW_BITS-1:0]  rem_reg;
    logic [NODE_W-1:0]    idx_reg;

    logic                 out_valid_reg;
    logic                 out_connected_reg;
    logic [NODE_W-1:0]    out_neighbor_reg;
    logic                 out_neighbor_valid_reg;
    logic                 out_last_reg;

    logic [ROW_BITS-1:0]  row_cur;
    logic [ROW_BITS-1:0]  bit_sel;
    logic [ROW_BITS-1:0]  row_new;
    logic [ROW_BITS-1:0]  limit_mask;
    logic [ROW_BITS-1:0]  row_masked;
    logic [CNT_W-1:0]     limit;
    logic                 emit_any;

    // A row never written since reset reads as empty.
    assign row_cur = row_valid_reg[a_reg] ? rd_row_reg : '0;
    assign bit_sel = {{(ROW_BITS-1){1'b0}}, 1'b1} << b_reg;
    assign row_new = (func_reg == FUNC_SET) ? (row_cur | bit_sel) : (row_cur & ~bit_sel);

    assign limit = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_reg;

    always_comb begin
        for (int i = 0; i < ROW_BITS; i++) begin
            limit_mask[i] = (CNT_W'(i) < limit);
        end
    end

    assign row_masked = row_cur & limit_mask;

    assign sts.func      = func_reg;
    assign sts.row_empty = (row_masked == '0);
    assign sts.rem_bit0  = rem_reg[0];
    assign sts.rem_last  = (rem_reg[ROW_BITS-1:1] == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_row_reg <= mem_reg[in_node_a];
        end
        if (cmd.write_row) begin
            mem_reg[a_reg] <= row_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg  <= '0;
            node_count_reg <= CNT_W'(MAX_NODES);
        end else begin
            if (cmd.write_row) begin
                row_valid_reg[a_reg] <= 1'b1;
            end
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= in_func;
            a_reg    <= in_node_a;
            b_reg    <= in_node_b;
        end
        if (cmd.load_scan) begin
            rem_reg <= row_masked;
            idx_reg <= '0;
        end else if (cmd.scan_step) begin
            rem_reg <= rem_reg >> 1;
            idx_reg <= idx_reg + NODE_W'(1);
        end
    end

    assign emit_any = cmd.emit_test || cmd.emit_empty || cmd.emit_neighbor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_any) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_any) begin
            out_connected_reg      <= cmd.emit_test ? row_cur[b_reg] : 1'b0;
            out_neighbor_reg       <= cmd.emit_neighbor ? idx_reg : '0;
            out_neighbor_valid_reg <= cmd.emit_neighbor;
            out_last_reg           <= cmd.emit_neighbor ? sts.rem_last : 1'b1;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_connected      = out_connected_reg;
    assign out_neighbor       = out_neighbor_reg;
    assign out_neighbor_valid = out_neighbor_valid_reg;
    assign out_last           = out_last_reg;

endmodule

// ===== tb/sv/adjacency_bit_matrix_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the adjacency bit matrix engine: tracks the edge matrix and node
// count from the observed input transactions and register writes, and compares each
// result transaction in order. Depends on abm_pkg.
module adjacency_bit_matrix_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [abm_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [15:0]               s_tdata,
    input  logic [1:0]                s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [7:0]                m_tdata,
    input  logic                      m_tlast,
    output int                        mismatch_count,
    output int                        results_pending
);
    import abm_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic              connected;
        logic [NODE_W-1:0] neighbor;
        logic              neighbor_valid;
        logic              last;
    } matrix_result_t;

    logic [ROW_BITS-1:0] edge_rows [MAX_NODES];
    logic [CNT_W-1:0]    node_count;
    matrix_result_t      expected_results [$];

    // Updates the matrix copy and queues the results one input transaction causes.
    task automatic predict_matrix_op(input logic [1:0] func, input logic [NODE_W-1:0] node_a,
                                     input logic [NODE_W-1:0] node_b);
        int scan_limit;
        int last_hit;
        matrix_result_t res;
        res = '0;
        case (func)
            FUNC_SET:   edge_rows[node_a][node_b] = 1'b1;
            FUNC_ERASE: edge_rows[node_a][node_b] = 1'b0;
            FUNC_TEST: begin
                res.connected = edge_rows[node_a][node_b];
                res.last = 1'b1;
                expected_results.insert(expected_results.size(), res);
            end
            default: begin
                // The scan never reaches past the row width, whatever the count says.
                scan_limit = (node_count > ROW_BITS) ? ROW_BITS : int'(node_count);
                last_hit = -1;
                for (int i = 0; i < scan_limit; i++) begin
                    if (edge_rows[node_a][i]) last_hit = i;
                end
                if (last_hit < 0) begin
                    res.last = 1'b1;
                    expected_results.insert(expected_results.size(), res);
                end else begin
                    for (int i = 0; i <= last_hit; i++) begin
                        if (edge_rows[node_a][i]) begin
                            res.neighbor = i[NODE_W-1:0];
                            res.neighbor_valid = 1'b1;
                            res.last = (i == last_hit);
                            expected_results.insert(expected_results.size(), res);
                        end
                    end
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin : monitor
        matrix_result_t got;
        matrix_result_t want;
        if (!aresetn) begin
            for (int r = 0; r < MAX_NODES; r++) edge_rows[r] = '0;
            node_count = CNT_W'(MAX_NODES);
            expected_results.delete();
            mismatch_count = 0;
            results_pending <= 0;
        end else begin
            if (cfg_wr_en) node_count = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[6:1], m_tdata[7], m_tlast};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: connected=%0d neighbor=%0d valid=%0d last=%0d",
                                 got.connected, got.neighbor, got.neighbor_valid, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"result mismatch: expected connected=%0d neighbor=%0d ",
                                      "valid=%0d last=%0d, got connected=%0d neighbor=%0d ",
                                      "valid=%0d last=%0d"},
                                     want.connected, want.neighbor, want.neighbor_valid,
                                     want.last, got.connected, got.neighbor,
                                     got.neighbor_valid, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_matrix_op(s_tuser, s_tdata[NODE_W-1:0], s_tdata[2*NODE_W-1:NODE_W]);
            results_pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/adjacency_bit_matrix_engine_test.sv =====
`timescale 1ns / 1ps
// Top of the adjacency bit matrix engine testbench: clock, reset, stimulus, result
// back-pressure and verdict. Depends on abm_pkg, the engine and adjacency_bit_matrix_checker.
module adjacency_bit_matrix_engine_test;
    import abm_pkg::*;

    localparam int CLK_HALF_NS      = 6;
    localparam int CYCLE_LIMIT      = 10_000_000;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 100;
    localparam int FULL_ROW         = 7;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic [15:0]      s_tdata     = '0;
    logic [1:0]       s_tuser     = '0;
    logic             m_tready    = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [7:0]       m_tdata;
    logic             m_tlast;

    int               mismatch_count;
    int               results_pending;
    int unsigned      cycle_count = 0;
    bit               steady_flow = 1'b0;
    bit               sink_hold_req = 1'b0;
    logic [NODE_W-1:0] hot_nodes [8];

    adjacency_bit_matrix_engine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    adjacency_bit_matrix_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("adjacency_bit_matrix_engine verification failed");
            $finish;
        end
    end

    // Result back-pressure. A hold request from the stimulus keeps tready low for a
    // long fixed stretch so the engine backs up into its input.
    initial begin : result_sink
        int span;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (steady_flow || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
                repeat (span) @(posedge aclk);
            end
        end
    end

    // Offers one transaction, after a random gap unless steady_flow is set, and returns at the edge that accepts it.
    task automatic send_item(input logic [1:0] func, input logic [NODE_W-1:0] node_a,
                             input logic [NODE_W-1:0] node_b);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 60) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0000, node_b, node_a};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering, waits for every queued result, then lets a late listing finish.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly operations on a few hot rows so edges build up and listings get long.
    task automatic random_items(input int count);
        int roll;
        logic [1:0] func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) func = FUNC_SET;
            else if (roll < 50) func = FUNC_ERASE;
            else if (roll < 75) func = FUNC_TEST;
            else func = FUNC_LIST;
            node_a = ($urandom_range(0, 3) != 0) ? hot_nodes[$urandom_range(0, 7)]
                                                 : NODE_W'($urandom_range(0, 63));
            node_b = ($urandom_range(0, 1) != 0) ? NODE_W'($urandom_range(0, 63))
                                                 : NODE_W'($urandom_range(0, 7));
            send_item(func, node_a, node_b);
        end
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] count_settings [6];
        count_settings[0] = CNT_W'(1);
        count_settings[1] = CNT_W'(0);
        count_settings[2] = CNT_W'(127);
        count_settings[3] = CNT_W'(33);
        count_settings[4] = CNT_W'($urandom_range(2, 63));
        count_settings[5] = CNT_W'(64);
        hot_nodes[0] = '0;
        hot_nodes[1] = '1;
        hot_nodes[2] = NODE_W'(FULL_ROW);
        for (int i = 3; i < 8; i++) hot_nodes[i] = NODE_W'($urandom_range(0, 63));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty matrix, corner edges, erasing a cleared edge and an emptied row.
        send_item(FUNC_TEST, NODE_W'(0), NODE_W'(0));
        send_item(FUNC_LIST, NODE_W'(0), NODE_W'(0));
        send_item(FUNC_LIST, NODE_W'(63), NODE_W'(63));
        send_item(FUNC_SET, NODE_W'(0), NODE_W'(0));
        send_item(FUNC_SET, NODE_W'(0), NODE_W'(63));
        send_item(FUNC_SET, NODE_W'(63), NODE_W'(0));
        send_item(FUNC_SET, NODE_W'(63), NODE_W'(63));
        send_item(FUNC_SET, NODE_W'(0), NODE_W'(31));
        send_item(FUNC_SET, NODE_W'(0), NODE_W'(32));
        send_item(FUNC_TEST, NODE_W'(0), NODE_W'(63));
        send_item(FUNC_TEST, NODE_W'(63), NODE_W'(63));
        send_item(FUNC_TEST, NODE_W'(0), NODE_W'(1));
        send_item(FUNC_LIST, NODE_W'(0), NODE_W'(17));
        send_item(FUNC_LIST, NODE_W'(63), NODE_W'(0));
        send_item(FUNC_ERASE, NODE_W'(0), NODE_W'(31));
        send_item(FUNC_ERASE, NODE_W'(0), NODE_W'(31));
        send_item(FUNC_ERASE, NODE_W'(5), NODE_W'(5));
        send_item(FUNC_TEST, NODE_W'(0), NODE_W'(31));
        send_item(FUNC_LIST, NODE_W'(0), NODE_W'(0));
        send_item(FUNC_SET, NODE_W'(42), NODE_W'(42));
        send_item(FUNC_TEST, NODE_W'(42), NODE_W'(42));
        send_item(FUNC_ERASE, NODE_W'(42), NODE_W'(42));
        send_item(FUNC_TEST, NODE_W'(42), NODE_W'(42));
        send_item(FUNC_LIST, NODE_W'(42), NODE_W'(42));

        random_items(50);

        // Fill one row completely, then list it while the result side is held off.
        for (int b = 0; b < ROW_BITS; b++) send_item(FUNC_SET, NODE_W'(FULL_ROW), NODE_W'(b));
        sink_hold_req = 1'b1;
        for (int i = 0; i < 10; i++) send_item(FUNC_LIST, NODE_W'(FULL_ROW), NODE_W'(0));
        settle_block();

        for (int p = 0; p < 6; p++) begin
            write_node_count(count_settings[p]);
            steady_flow = (p == 3);
            send_item(FUNC_LIST, NODE_W'(FULL_ROW), NODE_W'(0));
            send_item(FUNC_LIST, NODE_W'(0), NODE_W'(0));
            random_items(32);
            steady_flow = 1'b0;
        end

        settle_block();
        if (mismatch_count == 0)
            $display("adjacency_bit_matrix_engine verification clean");
        else
            $display("adjacency_bit_matrix_engine verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/abm_pkg.sv
rtl/abm_ctrl.sv
rtl/abm_datapath.sv
rtl/adjacency_bit_matrix_engine.sv
tb/sv/adjacency_bit_matrix_checker.sv
tb/sv/adjacency_bit_matrix_engine_test.sv
